// File: rtl/core/tbqe_pkg.sv
// Shared types and constants of the three-band biquad equalizer.
package tbqe_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 20;
  localparam int unsigned COEF_FRAC  = 17;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned GAIN_SHIFT = 6;   // *2^9 to Q7.24, then >>15 for Q1.15 gain
  localparam int unsigned NUM_COEF   = 5;
  localparam int unsigned MAX_BANDS  = 3;
  localparam int unsigned BAND_IDX_W = 2;
  localparam int unsigned CFG_DW     = 64;
  localparam int unsigned CFG_AW     = 6;
  localparam int unsigned CONV_FRAC  = 24;
  localparam int          ONE_Q24    = 16777216;
  localparam int          MAX_Q24    = 16776695;
  localparam int          OUT_SCALE  = 32767;

  localparam logic [COEF_W-1:0] COEF_UNITY = 20'h20000;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

  typedef enum logic [2:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2,
    REG_PRE_GAIN,
    REG_EQ_ENABLE
  } reg_idx_e;

  typedef logic [NUM_COEF-1:0][MAX_BANDS-1:0][COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t             coef;
    logic [GAIN_W-1:0] pre_gain;
    logic              enable;
  } cfg_t;

  typedef struct packed {
    logic rd;
    logic wr_z1;
    logic wr_z2;
    logic clear;
  } mem_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_X,
    ST_MB0,
    ST_Y,
    ST_A1,
    ST_B2,
    ST_A2,
    ST_Z2,
    ST_CONV,
    ST_RES,
    ST_OUT
  } state_e;

endpackage

// File: rtl/core/tbqe_item_if.sv
// Item channels of the equalizer: sample input and equalized output.
interface tbqe_in_if import tbqe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       channel;

  modport source (output valid, action, sample_in, channel, input ready);
  modport sink   (input valid, action, sample_in, channel, output ready);
endinterface

interface tbqe_out_if import tbqe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// File: rtl/core/tbqe_cfg_regs.sv
// APB configuration registers of the equalizer.
module tbqe_cfg_regs import tbqe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_AW-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef           <= coef_t'({MAX_BANDS{COEF_UNITY}});
      cfg_q.pre_gain       <= GAIN_UNITY;
      cfg_q.enable         <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: begin
          cfg_q.coef[idx] <= pwdata[MAX_BANDS*COEF_W-1:0];
        end
        REG_PRE_GAIN:  cfg_q.pre_gain <= pwdata[GAIN_W-1:0];
        REG_EQ_ENABLE: cfg_q.enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: begin
        prdata = CFG_DW'(cfg_q.coef[idx]);
      end
      REG_PRE_GAIN:  prdata = CFG_DW'(cfg_q.pre_gain);
      REG_EQ_ENABLE: prdata = CFG_DW'(cfg_q.enable);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/tbqe_delay_mem.sv
// Delay-term memories (z1, z2) per band and channel, with per-entry valid bits.
module tbqe_delay_mem import tbqe_pkg::*; #(
  parameter int unsigned DEPTH = 6,
  parameter int unsigned AW    = 3,
  parameter int unsigned SW    = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mem_ctl_t             ctl_i,
  input  logic [AW-1:0]        rd_addr_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic signed [SW-1:0] wdata_i,
  output logic signed [SW-1:0] z1_o,
  output logic signed [SW-1:0] z2_o
);

  logic [SW-1:0]    z1_mem [DEPTH];
  logic [SW-1:0]    z2_mem [DEPTH];
  logic [SW-1:0]    rd_z1_q;
  logic [SW-1:0]    rd_z2_q;
  logic             rd_valid_q;
  logic [DEPTH-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_z1) begin
      z1_mem[wr_addr_i] <= wdata_i;
    end
    if (ctl_i.wr_z2) begin
      z2_mem[wr_addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rd_z1_q <= z1_mem[rd_addr_i];
      rd_z2_q <= z2_mem[rd_addr_i];
    end
  end

  // an entry counts as written once its z2 lands; z1 of that entry is written earlier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        valid_q <= '0;
      end else if (ctl_i.wr_z2) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign z1_o = rd_valid_q ? $signed(rd_z1_q) : '0;
  assign z2_o = rd_valid_q ? $signed(rd_z2_q) : '0;

  a_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |-> !(ctl_i.rd || ctl_i.wr_z1 || ctl_i.wr_z2))
    else $error("clear overlaps a memory access");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.rd && (ctl_i.wr_z1 || ctl_i.wr_z2)) |-> (rd_addr_i != wr_addr_i))
    else $error("read and write hit the same entry");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> ($countones(valid_q) == 0))
    else $error("entries still valid after clear");

endmodule

// File: rtl/core/tbqe_engine.sv
// Sequencer and shared-multiplier datapath of the biquad cascade.
module tbqe_engine import tbqe_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 2,
  parameter int unsigned NUM_BANDS    = 3,
  parameter int unsigned SW           = 32,
  parameter int unsigned AW           = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  tbqe_in_if.sink              in_i,
  tbqe_out_if.source           res_o,
  output mem_ctl_t             mem_ctl_o,
  output logic [AW-1:0]        rd_addr_o,
  output logic [AW-1:0]        wr_addr_o,
  output logic signed [SW-1:0] wdata_o,
  input  logic signed [SW-1:0] z1_i,
  input  logic signed [SW-1:0] z2_i
);

  localparam int unsigned BW     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int unsigned WW     = SW + 5;
  localparam int unsigned PROD_W = SW + COEF_W;
  localparam int unsigned CV_W   = 26;
  localparam int unsigned CP_W   = CV_W + SAMPLE_W + 1;

  state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       ch_q, ch_d;
  logic [BW-1:0]              band_q, band_d;
  logic signed [SW-1:0]       x_q, x_d;
  logic signed [SW-1:0]       y_q, y_d;
  logic signed [WW-1:0]       acc_q, acc_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [CP_W-1:0]     cprod_q, cprod_d;
  logic                       low_q, low_d;
  logic signed [SAMPLE_W-1:0] res_q, res_d;
  logic signed [SAMPLE_W-1:0] out_data_q;
  logic                       out_valid_q;
  logic                       out_load;
  logic                       accept;
  logic                       last_band;

  reg_idx_e                   coef_sel;
  logic [BAND_IDX_W-1:0]      band_idx;
  logic signed [COEF_W-1:0]   mul_a;
  logic signed [SW-1:0]       mul_b;
  logic signed [PROD_W-1:0]   shr_coef;
  logic signed [PROD_W-1:0]   shr_gain;
  logic signed [WW-1:0]       term;
  logic signed [WW-1:0]       gained;
  logic signed [40:0]         v_ext;
  logic signed [CV_W-1:0]     v_clamp;
  logic signed [CP_W-1:0]     c_round;
  logic signed [CP_W-1:0]     c_shift;

  function automatic logic signed [SW-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [SW-1:0] r;
    if (&v[WW-1:SW-1] || ~|v[WW-1:SW-1]) begin
      r = v[SW-1:0];
    end else if (v[WW-1]) begin
      r = {1'b1, {(SW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [BW-1:0] b, input logic c);
    return AW'(AW'(b) * AW'(NUM_CHANNELS) + AW'(c));
  endfunction

  assign accept    = in_i.valid && in_i.ready;
  assign last_band = (band_q == BW'(NUM_BANDS - 1));
  assign band_idx  = BAND_IDX_W'(band_q);
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || res_o.ready);

  assign shr_coef = prod_q >>> COEF_FRAC;
  assign shr_gain = prod_q >>> GAIN_SHIFT;
  assign term     = shr_coef[WW-1:0];
  assign gained   = shr_gain[WW-1:0];
  assign prod_d   = PROD_W'(mul_a) * PROD_W'(mul_b);

  // output conversion: clamp to [-1, 0.999969], scale by 32767, truncate toward zero
  assign v_ext   = 41'(y_q);
  assign v_clamp = (v_ext > MAX_Q24) ? CV_W'(MAX_Q24) : v_ext[CV_W-1:0];
  assign c_round = cprod_q + CP_W'((ONE_Q24 - 1));
  assign c_shift = (cprod_q[CP_W-1] ? c_round : cprod_q) >>> CONV_FRAC;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.action) begin
            state_d = ST_IDLE;
          end else if (!cfg_i.enable) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_PRE;
          end
        end
      end
      ST_PRE:  state_d = ST_X;
      ST_X:    state_d = ST_MB0;
      ST_MB0:  state_d = ST_Y;
      ST_Y:    state_d = ST_A1;
      ST_A1:   state_d = ST_B2;
      ST_B2:   state_d = ST_A2;
      ST_A2:   state_d = ST_Z2;
      ST_Z2:   state_d = last_band ? ST_CONV : ST_MB0;
      ST_CONV: state_d = ST_RES;
      ST_RES:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    mem_ctl_o  = '0;
    rd_addr_o  = addr_of(band_q, ch_q);
    wr_addr_o  = addr_of(band_q, ch_q);
    wdata_o    = sat(acc_q);
    coef_sel   = REG_B0;
    mul_a      = '0;
    mul_b      = x_q;
    sample_d   = sample_q;
    ch_d       = ch_q;
    band_d     = band_q;
    x_d        = x_q;
    y_d        = y_q;
    acc_d      = acc_q;
    cprod_d    = cprod_q;
    low_d      = low_q;
    res_d      = res_q;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (accept) begin
          sample_d        = in_i.sample_in;
          ch_d            = in_i.channel && (NUM_CHANNELS > 1);
          band_d          = '0;
          res_d           = in_i.sample_in;
          mem_ctl_o.clear = in_i.action;
        end
      end
      ST_PRE: begin
        mul_a = $signed({{(COEF_W-GAIN_W){1'b0}}, cfg_i.pre_gain});
        mul_b = SW'(sample_q);
      end
      ST_X: begin
        x_d          = sat(gained);
        mem_ctl_o.rd = 1'b1;
      end
      ST_MB0: begin
        coef_sel = REG_B0;
        mul_a    = cfg_i.coef[coef_sel][band_idx];
      end
      ST_Y: begin
        y_d      = sat(term + WW'(z1_i));
        coef_sel = REG_B1;
        mul_a    = cfg_i.coef[coef_sel][band_idx];
      end
      ST_A1: begin
        acc_d    = term + WW'(z2_i);
        coef_sel = REG_A1;
        mul_a    = cfg_i.coef[coef_sel][band_idx];
        mul_b    = y_q;
      end
      ST_B2: begin
        acc_d    = acc_q - term;
        coef_sel = REG_B2;
        mul_a    = cfg_i.coef[coef_sel][band_idx];
      end
      ST_A2: begin
        mem_ctl_o.wr_z1 = 1'b1;
        wdata_o         = sat(acc_q);
        acc_d           = term;
        coef_sel        = REG_A2;
        mul_a           = cfg_i.coef[coef_sel][band_idx];
        mul_b           = y_q;
      end
      ST_Z2: begin
        mem_ctl_o.wr_z2 = 1'b1;
        wdata_o         = sat(acc_q - term);
        if (!last_band) begin
          band_d       = BW'(band_q + 1'b1);
          x_d          = y_q;
          mem_ctl_o.rd = 1'b1;
          rd_addr_o    = addr_of(BW'(band_q + 1'b1), ch_q);
        end
      end
      ST_CONV: begin
        low_d   = (v_ext <= -ONE_Q24);
        cprod_d = CP_W'(v_clamp) * CP_W'(OUT_SCALE);
      end
      ST_RES: begin
        res_d = low_q ? {1'b1, {(SAMPLE_W-1){1'b0}}} : c_shift[SAMPLE_W-1:0];
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    ch_q     <= ch_d;
    band_q   <= band_d;
    x_q      <= x_d;
    y_q      <= y_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    cprod_q  <= cprod_d;
    low_q    <= low_d;
    res_q    <= res_d;
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.sample_out = out_data_q;

endmodule

// File: rtl/core/three_band_biquad_equalizer_core.sv
// Three-band equalizer: cascaded TDF-II biquads (bass shelf, mid peak, treble
// shelf) on signed 16-bit PCM. A sample is scaled to Q7.24, multiplied by the
// Q1.15 pre-gain, filtered band by band with Q2.17 coefficients, clamped to
// [-1, 0.999969] and converted back to 16 bits. The delay terms of every band
// and channel sit in two small synchronous memories that are read once and
// written back once per band. One item is processed at a time, set by the
// single shared multiplier that does the pre-gain product and five products
// per band: a filtered sample passes the pre-gain, each band in turn and the
// output conversion before it reaches the output register, and only then is
// the next item taken. A pass-through sample (eq_enable low) skips the filter
// and goes to the output register unfiltered; a clear item gives no result.
// A result the receiver has not yet taken holds the next one back.
// Clear is a single-cycle invalidation of the delay memories; no clearing pass
// follows reset.
module three_band_biquad_equalizer_core import tbqe_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 2,
  parameter int unsigned NUM_BANDS    = 3,
  parameter int unsigned SIGNAL_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  tbqe_in_if.sink           in_i,
  tbqe_out_if.source        res_o
);

  localparam int unsigned DEPTH = NUM_BANDS * NUM_CHANNELS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t                           cfg;
  mem_ctl_t                       mem_ctl;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;
  logic signed [SIGNAL_WIDTH-1:0] wdata;
  logic signed [SIGNAL_WIDTH-1:0] z1;
  logic signed [SIGNAL_WIDTH-1:0] z2;

  tbqe_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbqe_delay_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .SW    (SIGNAL_WIDTH)
  ) u_delay_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wdata_i   (wdata),
    .z1_o      (z1),
    .z2_o      (z2)
  );

  tbqe_engine #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_BANDS    (NUM_BANDS),
    .SW           (SIGNAL_WIDTH),
    .AW           (AW)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .res_o     (res_o),
    .mem_ctl_o (mem_ctl),
    .rd_addr_o (rd_addr),
    .wr_addr_o (wr_addr),
    .wdata_o   (wdata),
    .z1_i      (z1),
    .z2_i      (z2)
  );

endmodule
